// ===== rtl/rgb_to_hsv_pixel_core_macros.svh =====
// Assertion macros shared by the RGB to HSV pixel core.
`ifndef RGB_TO_HSV_PIXEL_CORE_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHSV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rhsv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHSV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rhsv assertion failed");

`endif

// ===== rtl/rhsv_pkg.sv =====
// Types and constants for the RGB to HSV pixel core.
`default_nettype none

package rhsv_pkg;

    localparam int CH_W      = 8;                       // channel width
    localparam int N_W       = 11;                      // hue numerator, below 6*255
    localparam int QUO_W     = 8;                       // quotient bits, one per stage
    localparam int DEN_W     = 11;                      // divisor width (6*d or max)
    localparam int NUM_W     = N_W + CH_W;              // 255 * numerator
    localparam int FRONT_LAT = 2;                       // front end register stages
    localparam int PIPE_LAT  = FRONT_LAT + QUO_W + 1;   // start to done

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] value;
    } hsv_out_t;

    // Operands handed to one divider; zero forces a zero quotient.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             zero;
    } div_in_t;

    // State carried between divider stages.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             zero;
    } div_stage_t;

endpackage

`default_nettype wire

// ===== rtl/rhsv_front.sv =====
// Front end: max/min, sector select and divider operand setup (two stages).
`default_nettype none

module rhsv_front (
    input  wire logic                        clk,
    input  wire rhsv_pkg::pixel_in_t         pixel,
    output rhsv_pkg::div_in_t                hue_op,
    output rhsv_pkg::div_in_t                sat_op,
    output logic [rhsv_pkg::CH_W-1:0]        max_out
);

    logic [rhsv_pkg::CH_W-1:0] r, g, b;
    logic [rhsv_pkg::CH_W-1:0] mx_next, mn, d_next;
    logic [rhsv_pkg::N_W-1:0]  d6, n_red, n_grn, n_blu, n_next;

    logic [rhsv_pkg::CH_W-1:0] mx_reg, d_reg;
    logic [rhsv_pkg::N_W-1:0]  n_reg, d6_reg;

    rhsv_pkg::div_in_t         hue_next, sat_next;
    rhsv_pkg::div_in_t         hue_reg, sat_reg;
    logic [rhsv_pkg::CH_W-1:0] mx2_reg;

    assign r = pixel.red;
    assign g = pixel.green;
    assign b = pixel.blue;

    // Stage 1: extremes and hue numerator in units of d
    always_comb
    begin
        mx_next = r;
        if (g > mx_next)
        begin
            mx_next = g;
        end
        if (b > mx_next)
        begin
            mx_next = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        d_next = mx_next - mn;
        d6 = {1'b0, d_next, 2'b00} + {2'b00, d_next, 1'b0};

        // red sector wraps a negative g - b by a full turn
        if (g >= b)
        begin
            n_red = {3'b000, g - b};
        end
        else
        begin
            n_red = d6 - {3'b000, b - g};
        end
        n_grn = {2'b00, d_next, 1'b0} + {3'b000, b} - {3'b000, r};
        n_blu = {1'b0, d_next, 2'b00} + {3'b000, r} - {3'b000, g};

        priority if (mx_next == r)
        begin
            n_next = n_red;
        end
        else if (mx_next == g)
        begin
            n_next = n_grn;
        end
        else
        begin
            n_next = n_blu;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg <= mx_next;
        d_reg  <= d_next;
        n_reg  <= n_next;
        d6_reg <= d6;
    end

    // Stage 2: scale numerators by 255
    always_comb
    begin
        hue_next.num  = {n_reg, 8'h00} - {8'h00, n_reg};
        hue_next.den  = d6_reg;
        hue_next.zero = (d_reg == '0);
        sat_next.num  = {3'b000, d_reg, 8'h00} - {11'h000, d_reg};
        sat_next.den  = {3'b000, mx_reg};
        sat_next.zero = (mx_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= hue_next;
        sat_reg <= sat_next;
        mx2_reg <= mx_reg;
    end

    assign hue_op  = hue_reg;
    assign sat_op  = sat_reg;
    assign max_out = mx2_reg;

endmodule

`default_nettype wire

// ===== rtl/rhsv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, round half to even.
`default_nettype none

module rhsv_div (
    input  wire logic                        clk,
    input  wire rhsv_pkg::div_in_t           op,
    output logic [rhsv_pkg::QUO_W-1:0]       quo
);

    rhsv_pkg::div_stage_t stage_in   [rhsv_pkg::QUO_W];
    rhsv_pkg::div_stage_t stage_next [rhsv_pkg::QUO_W];
    rhsv_pkg::div_stage_t stage_reg  [rhsv_pkg::QUO_W];

    logic [rhsv_pkg::DEN_W-1:0] rem_lo;
    logic                       round_up;
    logic [rhsv_pkg::QUO_W-1:0] quo_next, quo_reg;

    always_comb
    begin
        stage_in[0].rem  = op.num;
        stage_in[0].den  = op.den;
        stage_in[0].quo  = '0;
        stage_in[0].zero = op.zero;
    end

    for (genvar s = 0; s < rhsv_pkg::QUO_W; s++)
    begin : g_stage
        localparam int SH = rhsv_pkg::QUO_W - 1 - s;
        logic [rhsv_pkg::NUM_W-1:0] trial;

        if (s > 0)
        begin : g_link
            assign stage_in[s] = stage_reg[s-1];
        end

        assign trial = {{(rhsv_pkg::NUM_W - rhsv_pkg::DEN_W){1'b0}}, stage_in[s].den} << SH;

        always_comb
        begin
            stage_next[s] = stage_in[s];
            if (stage_in[s].rem >= trial)
            begin
                stage_next[s].rem     = stage_in[s].rem - trial;
                stage_next[s].quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    // Final remainder is below the divisor, so it fits the divisor width
    always_comb
    begin
        rem_lo   = stage_reg[rhsv_pkg::QUO_W-1].rem[rhsv_pkg::DEN_W-1:0];
        round_up = ({rem_lo, 1'b0} > {1'b0, stage_reg[rhsv_pkg::QUO_W-1].den})
                || (({rem_lo, 1'b0} == {1'b0, stage_reg[rhsv_pkg::QUO_W-1].den})
                    && stage_reg[rhsv_pkg::QUO_W-1].quo[0]);
        if (stage_reg[rhsv_pkg::QUO_W-1].zero)
        begin
            quo_next = '0;
        end
        else
        begin
            quo_next = stage_reg[rhsv_pkg::QUO_W-1].quo + {{(rhsv_pkg::QUO_W-1){1'b0}}, round_up};
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsv_pixel_core.sv =====
// Top level of the RGB to HSV pixel core.
`default_nettype none
`include "rgb_to_hsv_pixel_core_macros.svh"

// RGB to HSV pixel core. Takes one 8-bit RGB pixel per clock and returns
// 8-bit hue (360 degrees maps to 255), saturation (255*range/max, rounded
// half to even) and value (max channel). A transaction is accepted on any
// clock edge with start high; busy is tied low, so a new pixel may enter
// on every cycle. Each result appears on 'result' for exactly one cycle
// with 'done' high, in input order. The receiver cannot stall the core,
// so nothing is buffered beyond the pipe. The pipe is made of two
// front-end stages (max/min and sector select, then scaling by 255),
// eight divider stages (one quotient bit each, two dividers side by
// side for hue and saturation) and one rounding stage that also drives
// the output register. Grey pixels give hue 0, black pixels give
// saturation 0. Only the valid pipeline is reset.

module rgb_to_hsv_pixel_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire rhsv_pkg::pixel_in_t  pixel,
    output logic                      done,
    output rhsv_pkg::hsv_out_t        result
);

    rhsv_pkg::div_in_t          hue_op, sat_op;
    logic [rhsv_pkg::CH_W-1:0]  max_val;
    logic [rhsv_pkg::QUO_W-1:0] hue_q, sat_q;

    // one valid bit per pipeline stage
    logic [rhsv_pkg::PIPE_LAT-1:0] valid_reg, valid_next;

    // value rides alongside the dividers
    logic [rhsv_pkg::CH_W-1:0] val_reg [rhsv_pkg::QUO_W+1];

    assign busy = 1'b0;

    rhsv_front u_front (
        .clk     (clk),
        .pixel   (pixel),
        .hue_op  (hue_op),
        .sat_op  (sat_op),
        .max_out (max_val)
    );

    rhsv_div u_hue_div (
        .clk (clk),
        .op  (hue_op),
        .quo (hue_q)
    );

    rhsv_div u_sat_div (
        .clk (clk),
        .op  (sat_op),
        .quo (sat_q)
    );

    assign valid_next = {valid_reg[rhsv_pkg::PIPE_LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg[0] <= max_val;
        for (int i = 1; i <= rhsv_pkg::QUO_W; i++)
        begin
            val_reg[i] <= val_reg[i-1];
        end
    end

    assign done              = valid_reg[rhsv_pkg::PIPE_LAT-1];
    assign result.hue        = hue_q;
    assign result.saturation = sat_q;
    assign result.value      = val_reg[rhsv_pkg::QUO_W];

    // a strobe only ever answers a transaction that was taken with start high
    `RHSV_ASSERT_IMP(a_done_latency, clk, rst_n, done, $past(start, rhsv_pkg::PIPE_LAT))
    // zero saturation means a grey pixel, whose hue must be zero
    `RHSV_ASSERT_IMP(a_grey_hue, clk, rst_n, done && result.saturation == '0, result.hue == '0)
    // black pixel gives zero saturation
    `RHSV_ASSERT_IMP(a_black_sat, clk, rst_n, done && result.value == '0, result.saturation == '0)
    // a transaction entering the last stage strobes on the next cycle
    `RHSV_ASSERT_NXT(a_strobe, clk, rst_n, valid_reg[rhsv_pkg::PIPE_LAT-2], done)

endmodule

`default_nettype wire
